FILE: hw/rtl/esf_pkg.sv
// Package for the escaped serial line framer.
// Holds command and kind codes, the escape byte and the front-to-back entry type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package esf_pkg;

  // Command codes carried in the slave tuser.
  localparam logic [2:0] CMD_TX    = 3'd0;
  localparam logic [2:0] CMD_RX    = 3'd1;
  localparam logic [2:0] CMD_LINES = 3'd2;
  localparam logic [2:0] CMD_CONN  = 3'd3;
  localparam logic [2:0] CMD_DISC  = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  // Result kinds carried in the master tuser.
  localparam logic [1:0] KIND_LINK   = 2'd0;
  localparam logic [1:0] KIND_LOCAL  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Escape byte and the two DTR control codes that may follow it.
  localparam logic [7:0] ESC_BYTE = 8'hFF;
  localparam logic [7:0] DTR_LOW  = 8'h00;
  localparam logic [7:0] DTR_HIGH = 8'h01;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One queued job: one or two output words with shared status.
  typedef struct packed {
    logic       two;      // a second word follows the first
    logic [1:0] kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       burst;
    logic       link_up;
    logic       dtr_up;
  } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/escaped_serial_line_framer.sv
// Escaped serial line framer: 0xFF byte stuffing with DTR/DCD/RI signalling.
// A job passes the queue slot register and then the output register.
// Throughput: one input word per cycle unless the queue is full, one result word
// per cycle unless stalled; doubled escapes and line announcements give two words.
// Reset: asynchronous, active low; clears line state, the job queue and output valid.
// Depends on esf_pkg, esf_front, esf_queue and esf_back.
`timescale 1ns / 1ps
`default_nettype none

module escaped_serial_line_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], dcd_in[8], ri_in[9], zeros
  input  wire logic [2:0]  s_axis_tuser,  // command[2:0]
  input  wire logic        s_axis_tlast,  // burst_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // out_byte[7:0], burst_end[8], link_up[9],
                                          // dtr_up[10], zeros
  output logic [1:0]       m_axis_tuser,  // kind[1:0]
  output logic             m_axis_tlast   // last_of_run
);

  esf_pkg::entry_t entry, head;
  logic            push, pop, full, empty, accept;
  logic [7:0]      out_byte;
  logic            burst_end, link_up, dtr_up;

  assign s_axis_tready = ~full;
  assign accept        = s_axis_tvalid & ~full;

  // Front: state keeping and classification.
  esf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .command_i    (s_axis_tuser),
    .data_byte_i  (s_axis_tdata[7:0]),
    .dcd_in_i     (s_axis_tdata[8]),
    .ri_in_i      (s_axis_tdata[9]),
    .burst_last_i (s_axis_tlast),
    .entry_o      (entry),
    .push_o       (push)
  );

  // Job queue.
  esf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back: word expansion and output register.
  esf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .kind_o        (m_axis_tuser),
    .out_byte_o    (out_byte),
    .last_of_run_o (m_axis_tlast),
    .burst_end_o   (burst_end),
    .link_up_o     (link_up),
    .dtr_up_o      (dtr_up)
  );

  assign m_axis_tdata = {5'd0, dtr_up, link_up, burst_end, out_byte};

endmodule

`default_nettype wire

FILE: hw/rtl/esf_front.sv
// Front part of the escaped serial line framer: accepts input words,
// keeps the line state and turns each word into at most one queued job.
// Depends on esf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [2:0]      command_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            dcd_in_i,
  input  wire logic            ri_in_i,
  input  wire logic            burst_last_i,
  output esf_pkg::entry_t      entry_o,
  output logic                 push_o
);

  logic conn_q, conn_d;
  logic esc_q, esc_d;
  logic dtr_q, dtr_d;
  logic dcd_q, dcd_d;
  logic ri_q, ri_d;
  logic push;
  esf_pkg::entry_t entry;

  // Classify the word and work out the next line state.
  always_comb begin
    conn_d = conn_q;
    esc_d  = esc_q;
    dtr_d  = dtr_q;
    dcd_d  = dcd_q;
    ri_d   = ri_q;
    push   = 1'b0;
    entry.two   = 1'b0;
    entry.kind  = esf_pkg::KIND_LINK;
    entry.byte0 = data_byte_i;
    entry.byte1 = esf_pkg::ESC_BYTE;
    case (command_i)
      esf_pkg::CMD_TX: begin
        if (conn_q) begin
          push      = 1'b1;
          entry.two = (data_byte_i == esf_pkg::ESC_BYTE);
        end
      end
      esf_pkg::CMD_RX: begin
        entry.kind = esf_pkg::KIND_LOCAL;
        if (conn_q) begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (data_byte_i == esf_pkg::DTR_LOW) begin
              dtr_d = 1'b0;
            end else if (data_byte_i == esf_pkg::DTR_HIGH) begin
              dtr_d = 1'b1;
            end else if (data_byte_i == esf_pkg::ESC_BYTE) begin
              push = 1'b1;
            end
          end else if (data_byte_i == esf_pkg::ESC_BYTE) begin
            esc_d = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
      end
      esf_pkg::CMD_LINES: begin
        entry.two   = 1'b1;
        entry.byte0 = esf_pkg::ESC_BYTE;
        entry.byte1 = {6'd0, ri_in_i, dcd_in_i};
        if ((dcd_in_i != dcd_q) || (ri_in_i != ri_q)) begin
          dcd_d = dcd_in_i;
          ri_d  = ri_in_i;
          push  = conn_q;
        end
      end
      esf_pkg::CMD_CONN: begin
        if (!conn_q) begin
          conn_d = 1'b1;
          dtr_d  = 1'b0;
          dcd_d  = 1'b0;
        end
      end
      esf_pkg::CMD_DISC: begin
        conn_d = 1'b0;
      end
      esf_pkg::CMD_QUERY: begin
        push        = 1'b1;
        entry.kind  = esf_pkg::KIND_STATUS;
        entry.byte0 = 8'd0;
      end
      default: begin
      end
    endcase
    entry.burst   = burst_last_i;
    entry.link_up = conn_d;
    entry.dtr_up  = conn_d & dtr_d;
  end

  // Line state registers, updated only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q <= 1'b0;
      esc_q  <= 1'b0;
      dtr_q  <= 1'b0;
      dcd_q  <= 1'b0;
      ri_q   <= 1'b0;
    end else if (accept_i) begin
      conn_q <= conn_d;
      esc_q  <= esc_d;
      dtr_q  <= dtr_d;
      dcd_q  <= dcd_d;
      ri_q   <= ri_d;
    end
  end

  assign entry_o = entry;
  assign push_o  = accept_i & push;

endmodule

`default_nettype wire

FILE: hw/rtl/esf_queue.sv
// Short job queue between the front and the back of the framer.
// Register based, one push and one pop per cycle. Depends on esf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire esf_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output esf_pkg::entry_t      head_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = $clog2(esf_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(esf_pkg::QUEUE_DEPTH + 1);

  esf_pkg::entry_t slot_q [esf_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(esf_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = slot_q[rd_ptr_q];

  // Storage slots, written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(esf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(esf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/esf_back.sv
// Back part of the framer: expands queued jobs into one or two output
// words and holds them in the output register. Depends on esf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire esf_pkg::entry_t head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_run_o,
  output logic                 burst_end_o,
  output logic                 link_up_o,
  output logic                 dtr_up_o
);

  logic       phase_q, phase_d;
  logic       valid_q, valid_d;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       last_q, burst_q, link_q, dtr_q;
  logic       load;
  logic       word_last;

  // A word is loaded when a job waits and the output register is free or its word is being taken.
  assign load      = ~empty_i & (~valid_q | m_tready_i);
  assign word_last = phase_q | ~head_i.two;
  assign pop_o     = load & word_last;

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      phase_d = ~word_last;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= head_i.kind;
      byte_q  <= phase_q ? head_i.byte1 : head_i.byte0;
      last_q  <= word_last;
      burst_q <= word_last & head_i.burst;
      link_q  <= head_i.link_up;
      dtr_q   <= head_i.dtr_up;
    end
  end

  assign m_tvalid_o    = valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign burst_end_o   = burst_q;
  assign link_up_o     = link_q;
  assign dtr_up_o      = dtr_q;

endmodule

`default_nettype wire
